>>> src/mcu_ycbcr_to_rgb_writer_assert.svh
// Assertion macros for the MCU YCbCr to RGB writer.
// Included by the top level; depends on nothing else.
`ifndef MCU_YCBCR_TO_RGB_WRITER_ASSERT_SVH
`define MCU_YCBCR_TO_RGB_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define YRW_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yrw assertion failed");

// Next-cycle implication, disabled while reset is low.
`define YRW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yrw assertion failed");

`endif

>>> src/mcu_yrw_pkg.sv
// Types and constants for the MCU YCbCr to RGB writer.
// No dependencies.
`default_nettype none

package mcu_yrw_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int ADDR_W      = 26;
    localparam int FRAC_BITS   = 14;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_H_SAMPLING  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_SAMPLING  = 2'd2;

    // JFIF coefficients, Q2.14
    localparam logic signed [15:0] COEF_CR_R = 16'sd22971;
    localparam logic signed [15:0] COEF_CB_G = 16'sd5638;
    localparam logic signed [15:0] COEF_CR_G = 16'sd11700;
    localparam logic signed [15:0] COEF_CB_B = 16'sd29032;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [ADDR_W-1:0] byte_address;
        logic              mcu_last;
    } t_out_beat;

    // Clamp a sampling factor to 1..4
    function automatic logic [2:0] clamp_factor(input logic [2:0] f);
        logic [2:0] r;
        if (f == 3'd0) begin
            r = 3'd1;
        end else if (f > 3'd4) begin
            r = 3'd4;
        end else begin
            r = f;
        end
        return r;
    endfunction

    // Drop the fraction bits of a Q.14 sum and saturate to 0..255
    function automatic logic [7:0] to_byte(input logic signed [25:0] s);
        logic [7:0] r;
        if (s[25]) begin
            r = 8'd0;
        end else if (|s[24:22]) begin
            r = 8'd255;
        end else begin
            r = s[21:14];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/mcu_ycbcr_to_rgb_writer.sv
// MCU YCbCr to RGB writer: color conversion plus RGB frame byte addressing.
// Depends on mcu_yrw_pkg and mcu_ycbcr_to_rgb_writer_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one beat per pixel,
//   Y with its Cb/Cr pair, in MCU raster order (rows of an MCU, MCUs left to
//   right, bands top to bottom).
//   Output channel (o_out_valid / i_out_stall / o_out_data): one beat per
//   input beat, in order: saturated R, G, B, the byte offset of the pixel's
//   red byte in a packed 3-byte RGB frame, and a flag on the last pixel of
//   each MCU.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): image width,
//   horizontal and vertical sampling factors. Write only while idle.
// Timing:
//   Two-stage pipeline. Stage 1 takes the pixel, its address and MCU-end
//   flag (the position counters step here); stage 2 does the color math
//   into the output register. An accepted beat moves from the stage 1
//   register to the output register, one beat per cycle while not stalled.
// Reset (synchronous, i_rst_n low): pipeline empties, MCU position and frame
//   cursor return to zero, config returns to width 8, factors 1.
// Backpressure: when i_out_stall holds a full output register, stage 1 keeps
//   moving only if it is empty; once both are full, o_in_stall rises.
`default_nettype none

`include "mcu_ycbcr_to_rgb_writer_assert.svh"

module mcu_ycbcr_to_rgb_writer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // pixel input
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire mcu_yrw_pkg::t_in_beat               i_in_data,
    // pixel output
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output mcu_yrw_pkg::t_out_beat                   o_out_data,
    // config writes
    input  wire logic                                i_cfg_we,
    input  wire logic [mcu_yrw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [mcu_yrw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import mcu_yrw_pkg::*;

    // Widest usable frame width, and the frame size where the cursor wraps
    localparam int W_HI = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam logic [63:0] FRAME_BYTES = 64'(MAX_WIDTH) * 64'(MAX_HEIGHT) * 64'd3;

    // ---------------- config registers ----------------
    logic [12:0] r_image_width;
    logic [2:0]  r_h_sampling;
    logic [2:0]  r_v_sampling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= 13'd8;
            r_h_sampling  <= 3'd1;
            r_v_sampling  <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                CFG_H_SAMPLING:  r_h_sampling  <= i_cfg_data[2:0];
                CFG_V_SAMPLING:  r_v_sampling  <= i_cfg_data[2:0];
                default: ;   // unmapped index: dropped
            endcase
        end
    end

    // Effective MCU geometry and width
    logic [5:0]  mcu_w;      // 8..32
    logic [5:0]  mcu_h;      // 8..32
    logic [12:0] width_eff;  // 8..W_HI

    always_comb begin
        mcu_w = {clamp_factor(r_h_sampling), 3'b000};
        mcu_h = {clamp_factor(r_v_sampling), 3'b000};
        if (r_image_width < 13'd8) begin
            width_eff = 13'd8;
        end else if (r_image_width > 13'(W_HI)) begin
            width_eff = 13'(W_HI);
        end else begin
            width_eff = r_image_width;
        end
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_s2_valid;
    logic s2_ready;
    logic s1_adv;
    logic in_fire;

    assign s2_ready    = !r_s2_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && s2_ready;
    assign o_in_stall  = r_s1_valid && !s2_ready;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // ---------------- MCU position and frame cursor ----------------
    logic [4:0]        r_mcu_column;
    logic [4:0]        r_mcu_row;
    logic [ADDR_W-1:0] r_frame_cursor;
    logic [11:0]       r_cursor_column;

    logic [4:0]        n_mcu_column;
    logic [4:0]        n_mcu_row;
    logic [ADDR_W-1:0] n_frame_cursor;
    logic [11:0]       n_cursor_column;

    logic              col_end;
    logic              mcu_end;
    logic [17:0]       row_x_w;     // row * width
    logic [18:0]       pix_ofs;     // pixel offset within the MCU window
    logic [20:0]       pix_ofs3;    // in bytes
    logic [ADDR_W-1:0] pix_addr;
    logic [4:0]        mcu_h_m1;
    logic [17:0]       band_px;     // (MCU height - 1) * width
    logic [19:0]       band_bytes;
    logic [6:0]        mcu_w3;
    logic [12:0]       col_sum;
    logic [26:0]       cur_next;
    logic [26:0]       cur_band;

    always_comb begin
        col_end = ({1'b0, r_mcu_column} + 6'd1) >= mcu_w;
        mcu_end = col_end && (({1'b0, r_mcu_row} + 6'd1) >= mcu_h);

        row_x_w  = {13'b0, r_mcu_row} * {5'b0, width_eff};
        pix_ofs  = {1'b0, row_x_w} + {14'b0, r_mcu_column};
        pix_ofs3 = {1'b0, pix_ofs, 1'b0} + {2'b0, pix_ofs};
        pix_addr = r_frame_cursor + {5'b0, pix_ofs3};

        mcu_h_m1   = 5'(mcu_h - 6'd1);
        band_px    = {13'b0, mcu_h_m1} * {5'b0, width_eff};
        band_bytes = {1'b0, band_px, 1'b0} + {2'b0, band_px};
        mcu_w3     = {mcu_w, 1'b0} + {1'b0, mcu_w};
        col_sum    = {1'b0, r_cursor_column} + {7'b0, mcu_w};
        cur_next   = {1'b0, r_frame_cursor} + {20'b0, mcu_w3};
        cur_band   = (col_sum >= width_eff) ? (cur_next + {7'b0, band_bytes}) : cur_next;

        n_mcu_column    = r_mcu_column;
        n_mcu_row       = r_mcu_row;
        n_frame_cursor  = r_frame_cursor;
        n_cursor_column = r_cursor_column;

        if (col_end) begin
            n_mcu_column = 5'd0;
            n_mcu_row    = r_mcu_row + 5'd1;
        end else begin
            n_mcu_column = r_mcu_column + 5'd1;
        end

        if (mcu_end) begin
            n_mcu_row = 5'd0;
            // band complete: back to the left edge, skip the rest of the band
            n_cursor_column = (col_sum >= width_eff) ? 12'd0 : col_sum[11:0];
            // wrap at the end of the largest frame
            n_frame_cursor = ({37'b0, cur_band} >= FRAME_BYTES) ? '0 : cur_band[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcu_column    <= '0;
            r_mcu_row       <= '0;
            r_frame_cursor  <= '0;
            r_cursor_column <= '0;
        end else if (in_fire) begin
            r_mcu_column    <= n_mcu_column;
            r_mcu_row       <= n_mcu_row;
            r_frame_cursor  <= n_frame_cursor;
            r_cursor_column <= n_cursor_column;
        end
    end

    // ---------------- stage 1: input register ----------------
    t_in_beat          r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix  <= i_in_data;
            r_s1_addr <= pix_addr;
            r_s1_last <= mcu_end;
        end
    end

    // ---------------- stage 2: color conversion ----------------
    logic signed [8:0]  cb_c;
    logic signed [8:0]  cr_c;
    logic signed [25:0] y_s;
    logic signed [24:0] p_cr_r;
    logic signed [24:0] p_cb_g;
    logic signed [24:0] p_cr_g;
    logic signed [24:0] p_cb_b;
    logic signed [25:0] sum_r;
    logic signed [25:0] sum_g;
    logic signed [25:0] sum_b;
    t_out_beat          n_out;

    always_comb begin
        cb_c   = $signed({1'b0, r_s1_pix.chroma_blue}) - 9'sd128;
        cr_c   = $signed({1'b0, r_s1_pix.chroma_red}) - 9'sd128;
        y_s    = $signed({4'b0, r_s1_pix.luma, 14'b0});
        p_cr_r = 25'(COEF_CR_R) * 25'(cr_c);
        p_cb_g = 25'(COEF_CB_G) * 25'(cb_c);
        p_cr_g = 25'(COEF_CR_G) * 25'(cr_c);
        p_cb_b = 25'(COEF_CB_B) * 25'(cb_c);
        sum_r  = y_s + {p_cr_r[24], p_cr_r};
        sum_g  = y_s - {p_cb_g[24], p_cb_g} - {p_cr_g[24], p_cr_g};
        sum_b  = y_s + {p_cb_b[24], p_cb_b};

        n_out.red          = to_byte(sum_r);
        n_out.green        = to_byte(sum_g);
        n_out.blue         = to_byte(sum_b);
        n_out.byte_address = r_s1_addr;
        n_out.mcu_last     = r_s1_last;
    end

    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // ---------------- assertions ----------------
    // The last pixel of an MCU returns the position to the MCU's top-left
    `YRW_ASSERT_NEXT(a_mcu_wrap, i_clk, i_rst_n, in_fire && mcu_end,
        (r_mcu_row == 5'd0) && (r_mcu_column == 5'd0))
    // Both stages full and the output blocked: input must be held off
    `YRW_ASSERT_NOW(a_full_stalls, i_clk, i_rst_n,
        r_s1_valid && r_s2_valid && i_out_stall, o_in_stall)
    // Output taken with nothing behind it: output empties
    `YRW_ASSERT_NEXT(a_drain, i_clk, i_rst_n,
        r_s2_valid && !i_out_stall && !r_s1_valid, !o_out_valid)

endmodule

`default_nettype wire

>>> bench/tb_mcu_ycbcr_to_rgb_writer.sv
// Self-checking bench for mcu_ycbcr_to_rgb_writer: color math, frame addressing, MCU flags.
// Needs mcu_yrw_pkg and the block itself. Random traffic on both channels, several
// frame geometries, and a scoreboard fed by a per-beat predictor.
`default_nettype none

module tb_mcu_ycbcr_to_rgb_writer;
    import mcu_yrw_pkg::*;

    localparam int                     STUCK_LIMIT = 1000;   // cycles with no beat or register write
    localparam int                     FRAME_BYTES = 4096 * 4096 * 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE   = 2'd3;   // decoded by nobody

    // ------------------------------------------------------------------
    // Clock and DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    always begin
        #10 clk = ~clk;
    end

    logic                   rst_n     = 1'b0;
    logic                   px_valid  = 1'b0;
    logic                   px_stall;
    t_in_beat               px_data   = '0;
    logic                   rgb_valid;
    logic                   rgb_stall = 1'b0;
    t_out_beat              rgb_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    mcu_ycbcr_to_rgb_writer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (px_valid),
        .o_in_stall  (px_stall),
        .i_in_data   (px_data),
        .o_out_valid (rgb_valid),
        .i_out_stall (rgb_stall),
        .o_out_data  (rgb_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_in_beat  pixels_to_send[$];     // filled by the sequencer, drained by the driver
    t_out_beat expected_pixels[$];    // predicted output beats, oldest first
    int        pixels_queued = 0;     // sequencer-owned
    int        results_seen  = 0;     // monitor-owned, updated on posedge
    int        beats_in      = 0;
    int        mismatches    = 0;
    int        stuck_cycles  = 0;
    logic      px_taken      = 1'b0;  // input beat accepted at the last posedge

    // A stretch with no idling on either side, somewhere in the middle of the run
    wire quiet = (beats_in >= 250) && (beats_in < 420);

    // ------------------------------------------------------------------
    // Predictor: register copies and MCU / frame position
    // ------------------------------------------------------------------
    logic [12:0] geo_width;
    logic [2:0]  geo_hs;
    logic [2:0]  geo_vs;
    int          pos_col;
    int          pos_row;
    int          frame_base;      // byte offset of the current MCU's top-left pixel
    int          band_col;        // pixel column of the current MCU

    function automatic int fold_factor(input logic [2:0] f);
        if (f == 3'd0) return 1;
        if (f > 3'd4) return 4;
        return int'(f);
    endfunction

    // Q2.14 sum -> byte: negative sums give 0, then drop fraction, then cap at 255
    function automatic logic [7:0] q14_to_byte(input int sum);
        int v;
        if (sum < 0) return 8'd0;
        v = sum >>> FRAC_BITS;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic convert_and_place(input t_in_beat px, output t_out_beat rgb);
        int     y;
        int     cb;
        int     cr;
        int     mw;
        int     mh;
        int     w;
        longint addr;
        longint next_base;
        logic   col_end;
        logic   mcu_end;
        y  = int'(px.luma) * 16384;
        cb = int'(px.chroma_blue) - 128;
        cr = int'(px.chroma_red) - 128;
        mw = 8 * fold_factor(geo_hs);
        mh = 8 * fold_factor(geo_vs);
        w  = int'(geo_width);
        if (w < 8) w = 8;
        if (w > 4096) w = 4096;
        col_end = (pos_col + 1 >= mw);
        mcu_end = col_end && (pos_row + 1 >= mh);

        rgb.red          = q14_to_byte(y + 22971 * cr);
        rgb.green        = q14_to_byte(y - 5638 * cb - 11700 * cr);
        rgb.blue         = q14_to_byte(y + 29032 * cb);
        addr             = longint'(frame_base) + (longint'(pos_row) * w + pos_col) * 3;
        rgb.byte_address = addr[ADDR_W-1:0];
        rgb.mcu_last     = mcu_end;

        // Step within the MCU; a position beyond a shrunk MCU ends the row at once
        if (!col_end) begin
            pos_col = (pos_col + 1) & 31;
        end else begin
            pos_col = 0;
            pos_row = (pos_row + 1) & 31;
        end
        if (mcu_end) begin
            next_base = longint'(frame_base) + mw * 3;
            pos_row   = 0;
            band_col  = band_col + mw;
            if (band_col >= w) begin
                // band done: skip the remaining pixel rows of this MCU row
                band_col  = 0;
                next_base = next_base + longint'(mh - 1) * w * 3;
            end
            if (next_base >= FRAME_BYTES) next_base = 0;
            frame_base = int'(next_base & 64'h3FF_FFFF);
            band_col   = band_col & 12'hFFF;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs move on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        logic     nxt_valid;
        t_in_beat nxt_data;
        logic     gap;
        nxt_valid = px_valid;
        nxt_data  = px_data;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            rgb_stall <= 1'b0;
        end else begin
            if (px_valid && px_taken) nxt_valid = 1'b0;
            // a held beat keeps its payload; a free slot may take the next pixel
            if (!nxt_valid) begin
                gap = !quiet && ($urandom_range(99) < 11);
                if (pixels_to_send.size() > 0 && !gap) begin
                    nxt_data  = pixels_to_send.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            rgb_stall <= !quiet && ($urandom_range(99) < 11);
        end
        px_valid <= nxt_valid;
        px_data  <= nxt_data;
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, predict, compare, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_beat want;
        logic      bad;
        if (!rst_n) begin
            geo_width    = 13'd8;
            geo_hs       = 3'd1;
            geo_vs       = 3'd1;
            pos_col      = 0;
            pos_row      = 0;
            frame_base   = 0;
            band_col     = 0;
            px_taken     <= 1'b0;
            stuck_cycles <= 0;
        end else begin
            px_taken <= px_valid && !px_stall;

            if (rgb_valid && !rgb_stall) begin
                results_seen <= results_seen + 1;
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: output beat with nothing pending: %p", rgb_data);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    bad  = (rgb_data.red !== want.red) || (rgb_data.green !== want.green) ||
                           (rgb_data.blue !== want.blue) ||
                           (rgb_data.byte_address !== want.byte_address) ||
                           (rgb_data.mcu_last !== want.mcu_last);
                    if (bad) begin
                        if (mismatches < 10)
                            $display({"ERROR: rgb %0d/%0d/%0d addr %0d last %0b, ",
                                      "expected %0d/%0d/%0d addr %0d last %0b"},
                                     rgb_data.red, rgb_data.green, rgb_data.blue,
                                     rgb_data.byte_address, rgb_data.mcu_last,
                                     want.red, want.green, want.blue,
                                     want.byte_address, want.mcu_last);
                        mismatches = mismatches + 1;
                    end
                end
            end

            if (px_valid && !px_stall) begin
                convert_and_place(px_data, want);
                expected_pixels.push_back(want);
                beats_in <= beats_in + 1;
            end

            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: geo_width = cfg_data[12:0];
                    CFG_H_SAMPLING:  geo_hs    = cfg_data[2:0];
                    CFG_V_SAMPLING:  geo_vs    = cfg_data[2:0];
                    default: ;
                endcase
            end

            // watchdog: any beat or register write counts as progress
            if ((px_valid && !px_stall) || (rgb_valid && !rgb_stall) || cfg_we) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", STUCK_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sampling registers get junk in the bits above the 3-bit field
    task automatic set_geometry(input int width, input int hs, input int vs);
        logic [CFG_DATA_W-1:0] val;
        write_reg(CFG_IMAGE_WIDTH, width[CFG_DATA_W-1:0]);
        val      = CFG_DATA_W'($urandom);
        val[2:0] = hs[2:0];
        write_reg(CFG_H_SAMPLING, val);
        val      = CFG_DATA_W'($urandom);
        val[2:0] = vs[2:0];
        write_reg(CFG_V_SAMPLING, val);
    endtask

    // Queue pixels on a rising edge (driver reads the queue on falling edges)
    task automatic queue_pixel(input t_in_beat px);
        pixels_to_send.push_back(px);
        pixels_queued = pixels_queued + 1;
    endtask

    task automatic queue_random(input int n);
        t_in_beat px;
        @(posedge clk);
        repeat (n) begin
            px.luma        = pick_sample();
            px.chroma_blue = pick_sample();
            px.chroma_red  = pick_sample();
            queue_pixel(px);
        end
    endtask

    // Sender holds off until every predicted beat is back, then lets the pipe empty
    task automatic drain();
        while (results_seen < pixels_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        // Color corners: black/white, chroma rails, saturation both ways, near-zero sums
        static logic [23:0] corner [24] = '{
            24'h00_80_80, 24'hFF_80_80, 24'h00_00_00, 24'hFF_FF_FF,
            24'h00_FF_FF, 24'hFF_00_00, 24'h00_00_FF, 24'hFF_FF_00,
            24'h80_00_80, 24'h80_FF_80, 24'h80_80_00, 24'h80_80_FF,
            24'h10_80_80, 24'hEB_F0_10, 24'h51_5A_F0, 24'h91_36_22,
            24'h29_F0_6E, 24'h01_7F_81, 24'hFE_81_7F, 24'h00_80_00,
            24'hFF_80_FF, 24'h55_AA_55, 24'hAA_55_AA, 24'h7F_80_81
        };
        int w;
        int hs;
        int vs;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Geometry straight out of reset: 8 pixels wide, 8x8 MCU
        @(posedge clk);
        foreach (corner[i]) queue_pixel(t_in_beat'(corner[i]));
        queue_random(60);
        drain();

        write_reg(CFG_SPARE, 13'h1FFF);
        set_geometry(16, 1, 1);        // two MCUs per band
        queue_random(130);
        drain();

        set_geometry(0, 0, 0);         // all clamp up to 8 / factor 1
        queue_random(70);
        drain();

        set_geometry(24, 2, 1);        // width not a multiple of the 16-pixel MCU
        queue_random(80);
        drain();

        set_geometry(8191, 7, 1);      // width clamps to 4096, factor 7 acts as 4
        queue_random(90);
        drain();

        set_geometry(32, 4, 4);        // 32x32 MCU, left unfinished
        queue_random(50);
        drain();

        set_geometry(8, 1, 2);         // shrink mid-MCU: old column lies past the edge
        queue_random(100);
        drain();

        set_geometry(5000, 3, 5);
        queue_random(40);
        drain();

        // Random small geometries until enough pixels have gone through
        while (pixels_queued < 750) begin
            hs = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 2);
            vs = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 2);
            w  = 8 * $urandom_range(1, 16);
            set_geometry(w, hs, vs);
            queue_random($urandom_range(30, 90));
            drain();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        if (expected_pixels.size() != 0)
            $display("ERROR: %0d predicted beats never came out", expected_pixels.size());
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
